### design/hsvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsvc_pkg;

   // Hue scale: 1/64 degree per unit
   localparam logic [14:0] HUE_TURN     = 15'd23040;
   localparam logic [11:0] HUE_SECTOR   = 12'd3840;
   localparam logic [12:0] HUE_SPAN     = 13'd7680;

   // Sector boundaries on the reduced hue
   localparam logic [14:0] HUE_BOUND_1  = 15'd3840;
   localparam logic [14:0] HUE_BOUND_2  = 15'd7680;
   localparam logic [14:0] HUE_BOUND_3  = 15'd11520;
   localparam logic [14:0] HUE_BOUND_4  = 15'd15360;
   localparam logic [14:0] HUE_BOUND_5  = 15'd19200;

   // Reciprocal of 15 scaled by 2^15, exact for dividends below 3840
   localparam logic [11:0] RECIP_15     = 12'd2185;
   localparam int          RECIP_SHIFT  = 15;

   // 60-degree sectors
   localparam logic [2:0] SEC_RED_YEL   = 3'd0;
   localparam logic [2:0] SEC_YEL_GRN   = 3'd1;
   localparam logic [2:0] SEC_GRN_CYN   = 3'd2;
   localparam logic [2:0] SEC_CYN_BLU   = 3'd3;
   localparam logic [2:0] SEC_BLU_MAG   = 3'd4;
   localparam logic [2:0] SEC_MAG_RED   = 3'd5;

   // Beat from the hue/chroma front end to the mixing back end
   typedef struct packed {
      logic [2:0]  sector;
      logic [11:0] weight;   // 3840 - |hm - 3840|, 0..3840
      logic [7:0]  chroma;
      logic [7:0]  value;
   } front_data_type;

endpackage

`default_nettype wire

### design/hsvc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hsvc_front
   import hsvc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire logic [14:0]    in_hue,
   input  wire logic [7:0]     in_sat,
   input  wire logic [7:0]     in_val,
   output logic                out_valid,
   input  wire logic           out_ready,
   output front_data_type      out_data
);

   logic           v1_ff;
   logic [14:0]    hue1_ff;
   logic [15:0]    prod1_ff;
   logic [7:0]     val1_ff;
   logic [14:0]    hue1_in;
   logic [15:0]    prod1_in;

   logic           v2_ff;
   front_data_type data2_ff;
   front_data_type data2_in;

   logic           rdy1;
   logic           rdy2;

   logic [16:0]    div_sum;
   logic [12:0]    hm;
   logic [12:0]    span_base;

   // Advance a stage when it is empty or its successor takes the beat
   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // Stage 1: fold hue into one turn, form value * saturation
   always_comb begin
      hue1_in  = (in_hue >= HUE_TURN) ? (in_hue - HUE_TURN) : in_hue;
      prod1_in = 16'(in_val) * 16'(in_sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         hue1_ff  <= hue1_in;
         prod1_ff <= prod1_in;
         val1_ff  <= in_val;
      end
   end

   // Stage 2: chroma by reciprocal of 255, sector and triangle weight
   always_comb begin
      div_sum = {1'b0, prod1_ff} + {9'd0, prod1_ff[15:8]} + 17'd1;
      data2_in.chroma = div_sum[15:8];
      data2_in.value  = val1_ff;

      if (hue1_ff < HUE_BOUND_1) begin
         data2_in.sector = SEC_RED_YEL;
      end else if (hue1_ff < HUE_BOUND_2) begin
         data2_in.sector = SEC_YEL_GRN;
      end else if (hue1_ff < HUE_BOUND_3) begin
         data2_in.sector = SEC_GRN_CYN;
      end else if (hue1_ff < HUE_BOUND_4) begin
         data2_in.sector = SEC_CYN_BLU;
      end else if (hue1_ff < HUE_BOUND_5) begin
         data2_in.sector = SEC_BLU_MAG;
      end else begin
         data2_in.sector = SEC_MAG_RED;
      end

      // start of the two-sector span
      if (hue1_ff < HUE_BOUND_2) begin
         span_base = 13'd0;
      end else if (hue1_ff < HUE_BOUND_4) begin
         span_base = HUE_SPAN;
      end else begin
         span_base = 13'(2 * HUE_SPAN);
      end
      hm = 13'(hue1_ff - {2'b00, span_base});

      // rising half gives hm, falling half gives span - hm
      if (hm < {1'b0, HUE_SECTOR}) begin
         data2_in.weight = hm[11:0];
      end else begin
         data2_in.weight = 12'(HUE_SPAN - hm);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         data2_ff <= data2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = data2_ff;

endmodule

`default_nettype wire

### design/hsvc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module hsvc_back
   import hsvc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire front_data_type in_data,
   output logic                out_valid,
   input  wire logic           out_stall,
   output logic [7:0]          out_red,
   output logic [7:0]          out_green,
   output logic [7:0]          out_blue
);

   typedef struct packed {
      logic [2:0]  sector;
      logic [7:0]  chroma;
      logic [7:0]  offset;
      logic [19:0] cw;
   } mul_data_type;

   typedef struct packed {
      logic [2:0]  sector;
      logic [7:0]  chroma;
      logic [7:0]  offset;
      logic [7:0]  second;
   } mix_data_type;

   logic         v3_ff;
   mul_data_type data3_ff;
   mul_data_type data3_in;

   logic         v4_ff;
   mix_data_type data4_ff;
   mix_data_type data4_in;

   logic         v5_ff;
   logic [7:0]   red5_ff;
   logic [7:0]   green5_ff;
   logic [7:0]   blue5_ff;
   logic [7:0]   red5_in;
   logic [7:0]   green5_in;
   logic [7:0]   blue5_in;

   logic         rdy3;
   logic         rdy4;
   logic         rdy5;

   logic [23:0]  recip_prod;
   logic [7:0]   rc;
   logic [7:0]   gc;
   logic [7:0]   bc;

   function automatic logic [7:0] clamp8(input logic [8:0] sum);
      clamp8 = sum[8] ? 8'hFF : sum[7:0];
   endfunction

   // Advance a stage when it is empty or its successor takes the beat
   assign rdy5     = !v5_ff || !out_stall;
   assign rdy4     = !v4_ff || rdy5;
   assign rdy3     = !v3_ff || rdy4;
   assign in_ready = rdy3;

   // Stage 3: chroma times weight, offset m = v - c
   always_comb begin
      data3_in.sector = in_data.sector;
      data3_in.chroma = in_data.chroma;
      data3_in.offset = in_data.value - in_data.chroma;
      data3_in.cw     = 20'(in_data.chroma) * 20'(in_data.weight);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && in_valid) begin
         data3_ff <= data3_in;
      end
   end

   // Stage 4: x = cw / 3840 as (cw >> 8) / 15 through a reciprocal
   always_comb begin
      recip_prod      = 24'(data3_ff.cw[19:8]) * 24'(RECIP_15);
      data4_in.sector = data3_ff.sector;
      data4_in.chroma = data3_ff.chroma;
      data4_in.offset = data3_ff.offset;
      data4_in.second = recip_prod[RECIP_SHIFT +: 8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (rdy4) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         data4_ff <= data4_in;
      end
   end

   // Stage 5: route c, x and zero by sector, add offset, saturate
   always_comb begin
      case (data4_ff.sector)
         SEC_RED_YEL: begin
            rc = data4_ff.chroma; gc = data4_ff.second; bc = 8'd0;
         end
         SEC_YEL_GRN: begin
            rc = data4_ff.second; gc = data4_ff.chroma; bc = 8'd0;
         end
         SEC_GRN_CYN: begin
            rc = 8'd0; gc = data4_ff.chroma; bc = data4_ff.second;
         end
         SEC_CYN_BLU: begin
            rc = 8'd0; gc = data4_ff.second; bc = data4_ff.chroma;
         end
         SEC_BLU_MAG: begin
            rc = data4_ff.second; gc = 8'd0; bc = data4_ff.chroma;
         end
         default: begin
            rc = data4_ff.chroma; gc = 8'd0; bc = data4_ff.second;
         end
      endcase
      red5_in   = clamp8({1'b0, rc} + {1'b0, data4_ff.offset});
      green5_in = clamp8({1'b0, gc} + {1'b0, data4_ff.offset});
      blue5_in  = clamp8({1'b0, bc} + {1'b0, data4_ff.offset});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (rdy5) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5 && v4_ff) begin
         red5_ff   <= red5_in;
         green5_ff <= green5_in;
         blue5_ff  <= blue5_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_red   = red5_ff;
   assign out_green = green5_ff;
   assign out_blue  = blue5_ff;

endmodule

`default_nettype wire

### design/hsv_to_rgb_converter_unit.sv
// HSV to RGB pixel converter, five register stages.
//
// Request channel (req_valid / req_stall): one HSV pixel per beat, hue in
// 1/64 degree units (23040 is a full turn, values up to 32767 are folded
// once), saturation and brightness 8-bit with 255 as full scale.
// Response channel (rsp_valid / rsp_stall): one 8-bit RGB pixel per beat,
// in request order.
//
// A pixel passes the stage 1 to stage 5 registers in order and then shows
// on rsp_*. Throughput: one pixel per cycle when nothing stalls; each stage
// holds at most one pixel and the deepest arithmetic per stage is one
// small multiply (value*saturation, chroma*weight, reciprocal of 15).
//
// Reset clears the stage valid bits only; the block is empty afterwards.
// While rsp_stall holds a pending response, the output stage freezes and
// earlier stages keep filling any empty slots; req_stall rises only once
// every stage ahead of the request holds a pixel. Nothing is dropped or
// repeated under stall.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter_unit
   import hsvc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [14:0] req_hue,
   input  wire logic [7:0]  req_saturation,
   input  wire logic [7:0]  req_brightness,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue
);

   logic           front_ready;
   logic           front_valid;
   logic           back_ready;
   front_data_type front_data;

   // Hue folding, chroma and sector weight
   hsvc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_hue    (req_hue),
      .in_sat    (req_saturation),
      .in_val    (req_brightness),
      .out_valid (front_valid),
      .out_ready (back_ready),
      .out_data  (front_data)
   );

   // Secondary component, channel routing and output register
   hsvc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (back_ready),
      .in_data   (front_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue)
   );

   assign req_stall = !front_ready;

   // Weight never exceeds one sector and sector code stays in range
   assert property (@(posedge clock) disable iff (reset)
      front_valid |-> (front_data.weight <= HUE_SECTOR) &&
                      (front_data.sector <= SEC_MAG_RED))
      else $error("front end weight or sector out of range");

   // Chroma never exceeds brightness
   assert property (@(posedge clock) disable iff (reset)
      front_valid |-> (front_data.chroma <= front_data.value))
      else $error("chroma above brightness");

   // Internal beat holds while the back end is full
   assert property (@(posedge clock) disable iff (reset)
      (front_valid && !back_ready) |=> (front_valid && $stable(front_data)))
      else $error("front end beat changed while held");

endmodule

`default_nettype wire
